>>> src/cag_pkg.sv
package cag_pkg;

	// Slot table geometry
	localparam int SLOT_COUNT = 4;
	localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
	localparam int SLOT_W     = 3;
	localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOT_COUNT);

	// Frame and command constants
	localparam logic [9:0] FRAME_BYTES = 10'd22;
	localparam logic [7:0] REBOOT_CMD  = 8'h07;
	localparam logic [7:0] CMD_FIRST   = 8'd1;
	localparam logic [7:0] CMD_LAST    = 8'd4;

	// Register reset values
	localparam logic [7:0]  CAP_RESET = 8'd10;
	localparam logic [31:0] IVL_RESET = 32'd100000;

	// Refill count saturates at this value
	localparam logic [7:0] SAT_COUNT = 8'd255;
	localparam int         CNT_W     = 8;
	localparam int         STEP_W    = $clog2(CNT_W);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOKEN_CAPACITY  = 1'b0,
		REG_REFILL_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_DISPATCH     = 4'd0,
		ST_REBOOT       = 4'd1,
		ST_NO_LINK      = 4'd2,
		ST_UNAUTH       = 4'd3,
		ST_BAD_LEN      = 4'd4,
		ST_NO_SLOT      = 4'd5,
		ST_RATE         = 4'd6,
		ST_HMAC         = 4'd7,
		ST_REPLAY       = 4'd8,
		ST_UNSUPPORTED  = 4'd9,
		ST_DISCONNECTED = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADMIT,
		S_ELAPSED,
		S_SATCHK,
		S_DIV,
		S_BUCKET,
		S_NONCE,
		S_DONE
	} state_t;

	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

	// Lookup result from the slot table
	typedef struct packed {
		logic      hit;
		slot_idx_t hit_idx;
		logic      free_ok;
		slot_idx_t free_idx;
	} slot_look_t;

	// Write command to the slot table
	typedef struct packed {
		logic        alloc;
		logic        free;
		logic        tokens_we;
		logic        refill_we;
		logic        nonce_we;
		slot_idx_t   idx;
		logic [15:0] handle;
		logic [7:0]  tokens;
		logic [63:0] now;
		logic [63:0] nonce;
	} slot_wr_t;

endpackage

>>> src/cag_sub.sv
module cag_sub (
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] diff,
	output logic        borrow
);
	// borrow set means a < b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> src/cag_slot_table.sv
module cag_slot_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           look_handle,
	output cag_pkg::slot_look_t   look,
	input  cag_pkg::slot_wr_t     wr,
	input  cag_pkg::slot_idx_t    rd_idx,
	output logic [7:0]            rd_tokens,
	output logic [63:0]           rd_last_refill,
	output logic [63:0]           rd_last_nonce
);
	import cag_pkg::*;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [15:0]           handle_q      [SLOT_COUNT];
	logic [63:0]           last_nonce_q  [SLOT_COUNT];
	logic [7:0]            tokens_q      [SLOT_COUNT];
	logic [63:0]           last_refill_q [SLOT_COUNT];

	// Lowest matching slot, lowest free slot
	always_comb begin
		look = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && handle_q[i] == look_handle) begin
				look.hit     = 1'b1;
				look.hit_idx = slot_idx_t'(i);
			end
			if (!valid_q[i]) begin
				look.free_ok  = 1'b1;
				look.free_idx = slot_idx_t'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.alloc) begin
			valid_q[wr.idx] <= 1'b1;
		end else if (wr.free) begin
			valid_q[wr.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.alloc) begin
			handle_q[wr.idx]      <= wr.handle;
			last_nonce_q[wr.idx]  <= '0;
			tokens_q[wr.idx]      <= wr.tokens;
			last_refill_q[wr.idx] <= wr.now;
		end else begin
			if (wr.tokens_we) begin
				tokens_q[wr.idx] <= wr.tokens;
			end
			if (wr.refill_we) begin
				last_refill_q[wr.idx] <= wr.now;
			end
			if (wr.nonce_we) begin
				last_nonce_q[wr.idx] <= wr.nonce;
			end
		end
	end

	assign rd_tokens      = tokens_q[rd_idx];
	assign rd_last_refill = last_refill_q[rd_idx];
	assign rd_last_nonce  = last_nonce_q[rd_idx];

	a_alloc_free_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.alloc && wr.free))
		else $error("slot allocated and freed in one cycle");

endmodule

>>> src/command_admission_gate_core.sv
// A disconnect or an early reject goes from ADMIT straight to DONE; a write
// that reaches the bucket passes ELAPSED, SATCHK, the 8-step refill divide on
// the shared 64-bit subtractor when needed, BUCKET and then NONCE if it passes.
// Input is taken only while idle, while one finished result may still wait in
// the output register.
// Reset: arst_n clears all slots and restores capacity 10, interval 100000 us.
module command_admission_gate_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [15:0] link_handle, [79:16] now_us, [80] link_found, [81] link_encrypted,
	// [82] link_bonded, [92:83] frame_length, [100:93] cmd_id,
	// [108:101] target_index, [172:109] nonce, [173] hmac_ok, [175:174] zero
	input  logic [175:0]                 s_tdata,
	// [0] operation
	input  logic                         s_tuser,
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [3:0] status, [6:4] dispatch_kind, [14:7] dispatch_target,
	// [17:15] slot_used, [23:18] zero
	output logic [23:0]                  m_tdata,
	// Configuration writes
	input  logic                         cfg_we,
	input  logic [cag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cag_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cag_pkg::*;

	// Configuration registers
	logic [7:0]  cap_q;
	logic [31:0] ivl_q;
	logic [31:0] ivl_eff;

	// Captured input transaction
	logic        op_q;
	logic [15:0] handle_q;
	logic [63:0] now_q;
	logic        found_q;
	logic        enc_q;
	logic        bonded_q;
	logic [9:0]  flen_q;
	logic [7:0]  cmd_q;
	logic [7:0]  target_q;
	logic [63:0] nonce_q;
	logic        hmac_q;

	// Sequencer and working registers
	state_t              state_q, state_d;
	status_t             status_q, status_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [63:0]         rem_q;
	logic [CNT_W-1:0]    count_q;
	logic [STEP_W-1:0]   step_q;

	// Result register
	logic                m_valid_q;
	logic [3:0]          m_status_q;
	logic [2:0]          m_kind_q;
	logic [7:0]          m_target_q;
	logic [SLOT_W-1:0]   m_slot_q;

	// Shared subtractor
	logic [63:0] sub_a, sub_b, sub_diff;
	logic        sub_borrow;

	// Slot table
	slot_look_t  look;
	slot_wr_t    wr;
	slot_idx_t   cur_idx;
	logic [7:0]  rd_tokens;
	logic [63:0] rd_last_refill;
	logic [63:0] rd_last_nonce;

	// Bucket arithmetic
	logic [8:0]  tok_sum;
	logic [7:0]  tok_new;

	logic in_xfer;
	logic out_load;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign cur_idx  = slot_q[SLOT_IDX_W-1:0];

	// A zero interval acts as one microsecond
	assign ivl_eff = (ivl_q == '0) ? 32'd1 : ivl_q;

	cag_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	cag_slot_table u_slots (
		.clk            (clk),
		.arst_n         (arst_n),
		.look_handle    (handle_q),
		.look           (look),
		.wr             (wr),
		.rd_idx         (cur_idx),
		.rd_tokens      (rd_tokens),
		.rd_last_refill (rd_last_refill),
		.rd_last_nonce  (rd_last_nonce)
	);

	// Refill: add the count, clamp to capacity; untouched when no whole interval has
	// accrued so a lowered capacity only bites at the next refill
	always_comb begin
		tok_sum = {1'b0, rd_tokens} + {1'b0, count_q};
		if (count_q == '0) begin
			tok_new = rd_tokens;
		end else if (tok_sum > {1'b0, cap_q}) begin
			tok_new = cap_q;
		end else begin
			tok_new = tok_sum[7:0];
		end
	end

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			ivl_q <= IVL_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOKEN_CAPACITY:  cap_q <= cfg_data[7:0];
				REG_REFILL_INTERVAL: ivl_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= s_tuser;
			handle_q <= s_tdata[15:0];
			now_q    <= s_tdata[79:16];
			found_q  <= s_tdata[80];
			enc_q    <= s_tdata[81];
			bonded_q <= s_tdata[82];
			flen_q   <= s_tdata[92:83];
			cmd_q    <= s_tdata[100:93];
			target_q <= s_tdata[108:101];
			nonce_q  <= s_tdata[172:109];
			hmac_q   <= s_tdata[173];
		end
	end

	// Sequencer: next state, subtractor operands, slot table writes
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		slot_d   = slot_q;
		sub_a    = '0;
		sub_b    = '0;
		wr        = '0;
		wr.idx    = cur_idx;
		wr.handle = handle_q;
		wr.now    = now_q;
		wr.nonce  = nonce_q;
		wr.tokens = cap_q;

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_ADMIT;
				end
			end
			S_ADMIT: begin
				slot_d  = SLOT_NONE;
				state_d = S_DONE;
				if (op_q) begin
					// Disconnect: free a matching slot, report it either way
					status_d = ST_DISCONNECTED;
					if (look.hit) begin
						wr.free = 1'b1;
						wr.idx  = look.hit_idx;
						slot_d  = SLOT_W'(look.hit_idx);
					end
				end else if (!found_q) begin
					status_d = ST_NO_LINK;
				end else if (!enc_q || !bonded_q) begin
					status_d = ST_UNAUTH;
				end else if (flen_q != FRAME_BYTES) begin
					status_d = ST_BAD_LEN;
				end else if (look.hit) begin
					slot_d  = SLOT_W'(look.hit_idx);
					state_d = S_ELAPSED;
				end else if (look.free_ok) begin
					// Allocation sticks even if the write is rejected later
					wr.alloc = 1'b1;
					wr.idx   = look.free_idx;
					slot_d   = SLOT_W'(look.free_idx);
					state_d  = S_ELAPSED;
				end else begin
					status_d = ST_NO_SLOT;
				end
			end
			S_ELAPSED: begin
				// elapsed = now - last_refill, wrapping
				sub_a   = now_q;
				sub_b   = rd_last_refill;
				state_d = S_SATCHK;
			end
			S_SATCHK: begin
				// elapsed >= 256 * interval exactly when elapsed/256 >= interval
				sub_a = {8'b0, rem_q[63:8]};
				sub_b = {32'b0, ivl_eff};
				state_d = sub_borrow ? S_DIV : S_BUCKET;
			end
			S_DIV: begin
				// One restoring quotient bit per cycle, MSB first
				sub_a = rem_q;
				sub_b = {32'b0, ivl_eff} << step_q;
				if (step_q == '0) begin
					state_d = S_BUCKET;
				end
			end
			S_BUCKET: begin
				wr.tokens_we = 1'b1;
				wr.refill_we = (count_q != '0);
				if (tok_new == '0) begin
					wr.tokens = tok_new;
					status_d  = ST_RATE;
					state_d   = S_DONE;
				end else begin
					wr.tokens = tok_new - 8'd1;
					if (!hmac_q) begin
						status_d = ST_HMAC;
						state_d  = S_DONE;
					end else begin
						state_d = S_NONCE;
					end
				end
			end
			S_NONCE: begin
				// nonce must rise strictly: last - nonce borrows
				sub_a   = rd_last_nonce;
				sub_b   = nonce_q;
				state_d = S_DONE;
				if (!sub_borrow) begin
					status_d = ST_REPLAY;
				end else begin
					wr.nonce_we = 1'b1;
					if (cmd_q == REBOOT_CMD) begin
						status_d = ST_REBOOT;
					end else if (cmd_q >= CMD_FIRST && cmd_q <= CMD_LAST) begin
						status_d = ST_DISPATCH;
					end else begin
						status_d = ST_UNSUPPORTED;
					end
				end
			end
			S_DONE: begin
				// Hold until the result register is free
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		status_q <= status_d;
		slot_q   <= slot_d;
		case (state_q)
			S_ELAPSED: begin
				rem_q <= sub_diff;
			end
			S_SATCHK: begin
				step_q  <= STEP_W'(CNT_W - 1);
				count_q <= sub_borrow ? '0 : SAT_COUNT;
			end
			S_DIV: begin
				if (!sub_borrow) begin
					rem_q           <= sub_diff;
					count_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Result register: load from DONE, drop on the outgoing transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= status_q;
			m_slot_q   <= slot_q;
			if (status_q == ST_DISPATCH) begin
				m_kind_q   <= cmd_q[2:0];
				m_target_q <= target_q;
			end else begin
				m_kind_q   <= '0;
				m_target_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_slot_q, m_target_q, m_kind_q, m_status_q};

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result appeared outside the done step");

	a_dispatch_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_status_q != ST_DISPATCH |-> m_kind_q == '0 && m_target_q == '0)
		else $error("dispatch fields set on a non-dispatch result");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BUCKET || state_q == S_NONCE |-> slot_q < SLOT_NONE)
		else $error("bucket or nonce step without a slot");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && $past(state_q) == S_SATCHK |-> count_q == '0)
		else $error("divide started with a nonzero count");

endmodule
